// ===== design/ivt_pkg.sv =====
package ivt_pkg;

  localparam int IDX_BITS = 7;
  localparam int WORD_BITS = 32;

  localparam logic [2:0] ACT_PUSH   = 3'd0;
  localparam logic [2:0] ACT_INSERT = 3'd1;
  localparam logic [2:0] ACT_POP    = 3'd2;
  localparam logic [2:0] ACT_REMOVE = 3'd3;
  localparam logic [2:0] ACT_SWAP   = 3'd4;
  localparam logic [2:0] ACT_SET    = 3'd5;
  localparam logic [2:0] ACT_GET    = 3'd6;
  localparam logic [2:0] ACT_TRUNC  = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_UP    = 2'd1;
  localparam logic [1:0] OP_DOWN  = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_RD   = 2'd1;
  localparam logic [1:0] SRC_LAST = 2'd2;

  typedef struct packed {
    logic [2:0]           action;
    logic [IDX_BITS-1:0]  index;
    logic [WORD_BITS-1:0] value;
    logic [IDX_BITS-1:0]  keep_count;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [WORD_BITS-1:0] read_value;
    logic [IDX_BITS-1:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [1:0] op;
    logic       collect;
  } cell_ctl_t;

endpackage

// ===== design/ivt_cell.sv =====
module ivt_cell #(
  parameter int POS = 0,
  parameter int EB = 32,
  parameter int PW = 7
) (
  input  logic              clk,
  input  ivt_pkg::cell_ctl_t ctl,
  input  logic [PW-1:0]     pos,
  input  logic [PW-1:0]     lim,
  input  logic [PW-1:0]     rd_sel,
  input  logic [PW-1:0]     last_sel,
  input  logic [EB-1:0]     wdata,
  input  logic [EB-1:0]     left_data,
  input  logic [EB-1:0]     right_data,
  input  logic [EB-1:0]     rd_in,
  input  logic [EB-1:0]     last_in,
  output logic [EB-1:0]     data,
  output logic [EB-1:0]     rd_out,
  output logic [EB-1:0]     last_out
);
  import ivt_pkg::*;

  localparam logic [PW-1:0] MY_POS = PW'(POS);

  logic [EB-1:0] data_r, data_nxt;
  logic [EB-1:0] rd_r, rd_nxt;
  logic [EB-1:0] last_r, last_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      OP_UP: begin
        if (MY_POS == pos) begin
          data_nxt = wdata;
        end else if (MY_POS > pos && MY_POS <= lim) begin
          data_nxt = left_data;
        end
      end
      OP_DOWN: begin
        if (MY_POS >= pos && MY_POS < lim) begin
          data_nxt = right_data;
        end
      end
      OP_WRITE: begin
        if (MY_POS == pos) begin
          data_nxt = wdata;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  // read chains drift toward cell 0, one cell per cycle while collect is high
  always_comb begin
    rd_nxt = rd_r;
    last_nxt = last_r;
    if (ctl.collect) begin
      rd_nxt = (MY_POS == rd_sel) ? data_r : rd_in;
      last_nxt = (MY_POS == last_sel) ? data_r : last_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    rd_r <= rd_nxt;
    last_r <= last_nxt;
  end

  assign data = data_r;
  assign rd_out = rd_r;
  assign last_out = last_r;

endmodule

// ===== design/indexed_vector_table_unit.sv =====
// Ordered table of up to CAPACITY entries held in a row of cells, one entry per
// cell. One request is taken when start is high and busy is low; its response
// shows on out_response for exactly one cycle with out_valid high, and the
// receiver cannot stall it. Push, insert, set, truncate and any refused request
// go from accept through S_APPLY to the registered strobe, and a new request may
// be started in the strobe cycle. Pop, remove, swap remove and get pass through
// S_COLLECT first: the entry read travels down the cell row to cell 0 one cell
// per cycle, and tick_r holds S_COLLECT until it has covered the row. Shifts
// for insert and remove move every entry from the index up at once in S_APPLY.
module indexed_vector_table_unit #(
  parameter int CAPACITY = 64,
  parameter int ENTRY_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ivt_pkg::req_t in_request,
  output logic          out_valid,
  output ivt_pkg::rsp_t out_response
);
  import ivt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > IDX_BITS) ? CW : IDX_BITS;
  localparam int TW = $clog2(CAPACITY);
  localparam int EB = ENTRY_BITS;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_COLLECT = 2'd1;
  localparam logic [1:0] S_APPLY   = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [TW-1:0] tick_r, tick_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;
  rsp_t          out_r;

  logic [1:0]    op_r;
  logic          swap_r;
  logic [1:0]    src_r;
  logic [1:0]    status_r;
  logic [CW-1:0] newcnt_r;
  logic [PW-1:0] pos_r, lim_r, rd_sel_r, last_sel_r;
  logic [EB-1:0] wdata_r;

  logic [1:0]    d_op;
  logic          d_swap;
  logic          d_collect;
  logic [1:0]    d_src;
  logic [1:0]    d_status;
  logic [CW-1:0] d_newcnt;
  logic [PW-1:0] d_pos, d_lim, d_rd_sel, d_last_sel;
  logic [EB-1:0] in_word;

  logic [EB-1:0] data_w [CAPACITY];
  logic [EB-1:0] rd_w   [CAPACITY];
  logic [EB-1:0] last_w [CAPACITY];

  cell_ctl_t     ctl;
  logic [EB-1:0] cell_wdata;
  logic [EB-1:0] rd_word;
  logic [WORD_BITS-1:0] rd_out32;
  logic          accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy = (state_r != S_IDLE);

  generate
    if (EB == WORD_BITS) begin : g_equal
      assign in_word = in_request.value;
      assign rd_out32 = rd_word;
    end else if (EB < WORD_BITS) begin : g_narrow
      assign in_word = in_request.value[EB-1:0];
      assign rd_out32 = {{(WORD_BITS - EB){1'b0}}, rd_word};
    end else begin : g_wide
      assign in_word = {{(EB - WORD_BITS){1'b0}}, in_request.value};
      assign rd_out32 = rd_word[WORD_BITS-1:0];
    end
  endgenerate

  always_comb begin
    logic [PW-1:0] n;
    logic [PW-1:0] idx;
    logic [PW-1:0] keep;
    logic [PW-1:0] ins;
    n = PW'(count_r);
    idx = PW'(in_request.index);
    keep = PW'(in_request.keep_count);
    ins = (in_request.action == ACT_PUSH) ? n : idx;
    d_op = OP_NONE;
    d_swap = 1'b0;
    d_collect = 1'b0;
    d_src = SRC_NONE;
    d_status = ST_OK;
    d_newcnt = count_r;
    d_pos = idx;
    d_lim = n;
    d_rd_sel = idx;
    d_last_sel = n - PW'(1);
    unique case (in_request.action)
      ACT_PUSH, ACT_INSERT: begin
        d_pos = ins;
        if (ins > n) begin
          d_status = ST_RANGE;
        end else if (count_r == CW'(CAPACITY)) begin
          d_status = ST_FULL;
        end else begin
          d_op = OP_UP;
          d_newcnt = count_r + CW'(1);
        end
      end
      ACT_POP: begin
        if (count_r == '0) begin
          d_status = ST_RANGE;
        end else begin
          d_collect = 1'b1;
          d_src = SRC_LAST;
          d_newcnt = count_r - CW'(1);
        end
      end
      ACT_REMOVE: begin
        if (idx >= n) begin
          d_status = ST_RANGE;
        end else begin
          d_collect = 1'b1;
          d_src = SRC_RD;
          d_op = OP_DOWN;
          d_lim = n - PW'(1);
          d_newcnt = count_r - CW'(1);
        end
      end
      ACT_SWAP: begin
        if (idx >= n) begin
          d_status = ST_RANGE;
        end else begin
          d_collect = 1'b1;
          d_src = SRC_RD;
          d_op = OP_WRITE;
          d_swap = 1'b1;
          d_newcnt = count_r - CW'(1);
        end
      end
      ACT_SET: begin
        if (idx >= n) begin
          d_status = ST_RANGE;
        end else begin
          d_op = OP_WRITE;
        end
      end
      ACT_GET: begin
        if (idx >= n) begin
          d_status = ST_RANGE;
        end else begin
          d_collect = 1'b1;
          d_src = SRC_RD;
        end
      end
      ACT_TRUNC: begin
        if (keep < n) begin
          d_newcnt = CW'(keep);
        end
      end
      default: d_status = ST_OK;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    tick_nxt = tick_r;
    count_nxt = count_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          tick_nxt = '0;
          state_nxt = d_collect ? S_COLLECT : S_APPLY;
        end
      end
      S_COLLECT: begin
        tick_nxt = tick_r + TW'(1);
        if (tick_r == TW'(CAPACITY - 1)) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        count_nxt = newcnt_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tick_r <= '0;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tick_r <= tick_nxt;
      count_r <= count_nxt;
      out_valid_r <= (state_r == S_APPLY);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= d_op;
      swap_r <= d_swap;
      src_r <= d_src;
      status_r <= d_status;
      newcnt_r <= d_newcnt;
      pos_r <= d_pos;
      lim_r <= d_lim;
      rd_sel_r <= d_rd_sel;
      last_sel_r <= d_last_sel;
      wdata_r <= in_word;
    end
    if (state_r == S_APPLY) begin
      out_r.status <= status_r;
      out_r.read_value <= rd_out32;
      out_r.entry_count <= IDX_BITS'(newcnt_r);
    end
  end

  always_comb begin
    case (src_r)
      SRC_RD:   rd_word = rd_w[0];
      SRC_LAST: rd_word = last_w[0];
      default:  rd_word = '0;
    endcase
  end

  assign ctl.op = (state_r == S_APPLY) ? op_r : OP_NONE;
  assign ctl.collect = (state_r == S_COLLECT);
  assign cell_wdata = swap_r ? last_w[0] : wdata_r;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [EB-1:0] left_d, right_d, rd_i, last_i;
      if (gi == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_mid_l
        assign left_d = data_w[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_d = '0;
        assign rd_i = '0;
        assign last_i = '0;
      end else begin : g_mid_r
        assign right_d = data_w[gi+1];
        assign rd_i = rd_w[gi+1];
        assign last_i = last_w[gi+1];
      end
      ivt_cell #(
        .POS(gi),
        .EB(EB),
        .PW(PW)
      ) u_cell (
        .clk(clk),
        .ctl(ctl),
        .pos(pos_r),
        .lim(lim_r),
        .rd_sel(rd_sel_r),
        .last_sel(last_sel_r),
        .wdata(cell_wdata),
        .left_data(left_d),
        .right_data(right_d),
        .rd_in(rd_i),
        .last_in(last_i),
        .data(data_w[gi]),
        .rd_out(rd_w[gi]),
        .last_out(last_w[gi])
      );
    end
  endgenerate

  assign out_valid = out_valid_r;
  assign out_response = out_r;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import ivt_pkg::*;

  localparam int CAPACITY = 64;
  localparam int RANDOM_REQUESTS = 900;
  localparam int DRAIN_CYCLES = CAPACITY + 8;
  localparam int CYCLE_LIMIT = 500000;

  class table_scoreboard;
    logic [WORD_BITS-1:0] entries [CAPACITY];
    int unsigned fill;
    int errors;
    rsp_t expected_responses [$];

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function rsp_t apply_request(req_t r);
      rsp_t rsp;
      int unsigned n;
      int unsigned pos;
      int unsigned i;
      rsp = '0;
      rsp.status = ST_OK;
      n = fill;
      case (r.action)
        ACT_PUSH, ACT_INSERT: begin
          pos = (r.action == ACT_PUSH) ? n : r.index;
          if (pos > n) begin
            rsp.status = ST_RANGE;
          end else if (n >= CAPACITY) begin
            rsp.status = ST_FULL;
          end else begin
            for (i = n; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = r.value;
            n++;
          end
        end
        ACT_POP: begin
          if (n == 0) begin
            rsp.status = ST_RANGE;
          end else begin
            n--;
            rsp.read_value = entries[n];
          end
        end
        ACT_REMOVE: begin
          if (r.index >= n) begin
            rsp.status = ST_RANGE;
          end else begin
            rsp.read_value = entries[r.index];
            for (i = r.index; i + 1 < n; i++) entries[i] = entries[i+1];
            n--;
          end
        end
        ACT_SWAP: begin
          if (r.index >= n) begin
            rsp.status = ST_RANGE;
          end else begin
            rsp.read_value = entries[r.index];
            n--;
            if (r.index != n) entries[r.index] = entries[n];
          end
        end
        ACT_SET: begin
          if (r.index >= n) rsp.status = ST_RANGE;
          else entries[r.index] = r.value;
        end
        ACT_GET: begin
          if (r.index >= n) rsp.status = ST_RANGE;
          else rsp.read_value = entries[r.index];
        end
        default: begin
          if (r.keep_count < n) n = r.keep_count;
        end
      endcase
      fill = n;
      rsp.entry_count = n[IDX_BITS-1:0];
      return rsp;
    endfunction

    function void record_request(req_t r);
      expected_responses.push_back(apply_request(r));
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_responses.size() == 0) begin
        $error("response with none outstanding: %h", got);
        errors++;
        return;
      end
      want = expected_responses.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %h, got %h", want.read_value, got.read_value);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
        errors++;
      end
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_request;
  logic out_valid;
  rsp_t out_response;

  table_scoreboard sb;
  int cycle_count = 0;
  int sent;
  bit no_idle;

  indexed_vector_table_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_request   (in_request),
    .out_valid    (out_valid),
    .out_response (out_response)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_response(out_response);
  end

  function automatic req_t make_request(logic [2:0] act, logic [6:0] idx,
                                        logic [31:0] val, logic [6:0] keep);
    req_t r;
    r.action = act;
    r.index = idx;
    r.value = val;
    r.keep_count = keep;
    return r;
  endfunction

  function automatic logic [6:0] pick_index(int unsigned n);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70 && n > 0) return 7'($urandom_range(0, n - 1));
    if (roll < 85) return 7'(n);
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [6:0] pick_keep(int unsigned n);
    if ($urandom_range(0, 9) < 7) return 7'($urandom_range(0, n));
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic req_t random_request(logic [2:0] act);
    return make_request(act, pick_index(sb.fill), pick_value(), pick_keep(sb.fill));
  endfunction

  function automatic logic [2:0] pick_drain_action();
    case ($urandom_range(0, 2))
      0: return ACT_POP;
      1: return ACT_REMOVE;
      default: return ACT_SWAP;
    endcase
  endfunction

  task automatic send_request(req_t r);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_request <= r;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.record_request(r);
    sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned kind;
    sb = new();
    sent = 0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_request = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty table
    send_request(make_request(ACT_POP, 7'd0, '1, 7'd127));
    send_request(make_request(ACT_GET, 7'd0, '0, 7'd0));
    send_request(make_request(ACT_REMOVE, 7'd0, '1, 7'd0));
    send_request(make_request(ACT_SWAP, 7'd0, '0, 7'd127));
    send_request(make_request(ACT_SET, 7'd0, '1, 7'd0));
    send_request(make_request(ACT_INSERT, 7'd1, '1, 7'd0));
    send_request(make_request(ACT_TRUNC, 7'd127, '0, 7'd127));
    // build a few entries
    send_request(make_request(ACT_INSERT, 7'd0, 32'hFFFF_FFFF, 7'd0));
    send_request(make_request(ACT_PUSH, 7'd127, 32'h0000_0000, 7'd127));
    send_request(make_request(ACT_PUSH, 7'd0, 32'h5A5A_5A5A, 7'd0));
    send_request(make_request(ACT_INSERT, 7'd1, 32'hA5A5_A5A5, 7'd0));
    send_request(make_request(ACT_GET, 7'd3, '0, 7'd0));
    send_request(make_request(ACT_GET, 7'd4, '0, 7'd0));
    send_request(make_request(ACT_GET, 7'd127, '1, 7'd127));
    send_request(make_request(ACT_SET, 7'd0, 32'h1234_5678, 7'd0));
    send_request(make_request(ACT_SET, 7'd127, 32'hDEAD_BEEF, 7'd0));
    // swap of last entry, then of the first
    send_request(make_request(ACT_SWAP, 7'd3, '0, 7'd0));
    send_request(make_request(ACT_SWAP, 7'd0, '0, 7'd0));
    send_request(make_request(ACT_REMOVE, 7'd127, '0, 7'd0));
    send_request(make_request(ACT_REMOVE, 7'd1, '0, 7'd0));
    send_request(make_request(ACT_INSERT, 7'd5, 32'h0F0F_0F0F, 7'd0));
    send_request(make_request(ACT_TRUNC, 7'd0, '0, 7'd127));
    send_request(make_request(ACT_TRUNC, 7'd0, '0, 7'd1));
    send_request(make_request(ACT_POP, 7'd0, '0, 7'd0));
    send_request(make_request(ACT_POP, 7'd0, '0, 7'd0));
    wait_drained();

    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        while (sb.fill < CAPACITY) begin
          send_request(make_request($urandom_range(0, 1) ? ACT_PUSH : ACT_INSERT,
                                    7'($urandom_range(0, sb.fill)), pick_value(),
                                    pick_keep(sb.fill)));
        end
        repeat ($urandom_range(1, 3))
          send_request(random_request($urandom_range(0, 1) ? ACT_PUSH : ACT_INSERT));
      end else if (kind < 4) begin
        while (sb.fill != 0) begin
          send_request(make_request(pick_drain_action(),
                                    7'($urandom_range(0, sb.fill - 1)),
                                    pick_value(), pick_keep(sb.fill)));
        end
        send_request(random_request(pick_drain_action()));
      end else begin
        repeat ($urandom_range(16, 40))
          send_request(random_request(3'($urandom_range(ACT_PUSH, ACT_TRUNC))));
      end
      if ($urandom_range(0, 4) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
